### design/saqmf_pkg.sv
package saqmf_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned COEF_W   = 15;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH0_K1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH0_K2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH1_K1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH1_K2 = 3'd3;

    // Lattice micro-operations, one product each
    typedef enum logic [1:0] {
        OP_OUTER_IN  = 2'd0,  // t = x - k2*m2
        OP_OUTER_OUT = 2'd1,  // y = k2*t + m2
        OP_INNER_IN  = 2'd2,  // t = t - k1*m1
        OP_INNER_OUT = 2'd3   // m2 = m1 + k1*t
    } lat_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } state_t;

    // Arithmetic shift right by one
    function automatic logic [SAMPLE_W-1:0] halve(input logic [SAMPLE_W-1:0] v);
        halve = {v[SAMPLE_W-1], v[SAMPLE_W-1:1]};
    endfunction

endpackage

### design/stereo_allpass_qmf_analysis_top.sv
// Stereo two-band allpass QMF analysis.
// Input channel: in_valid/in_ready with left_sample and right_sample, one
// stereo pair per item. Output channel: out_valid/out_ready with left_low,
// right_low, left_high, right_high. Samples alternate in phase: the first item
// after reset is even phase. An odd-phase item runs the odd branch, stores its
// halved output and gives no result. An even-phase item runs the even branch
// and gives one result: low = half0 + held half1, high = half0 - held half1.
// After acceptance an item runs the eight lattice products on one shared
// 16x32 multiplier, each as a multiply state then an accumulate state. An
// even item then passes through a final state that loads the output register
// and raises out_valid. in_ready is high only while idle, so the next item is
// taken only once the last is done: after its last accumulate for an odd item,
// after the final state for an even one. A finished result waits in the
// output register; if it is still untaken when the next even item completes,
// the block holds in its final state until out_ready frees the register.
// Reset clears coefficients, lattice delays, held halves and phase at once.
// The user must write coefficients through cfg_write_en/cfg_index/cfg_data
// only while idle; the block itself does not enforce this.
module stereo_allpass_qmf_analysis_top
    import saqmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SAMPLE_W-1:0]  left_sample,
    input  logic [SAMPLE_W-1:0]  right_sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SAMPLE_W-1:0]  left_low,
    output logic [SAMPLE_W-1:0]  right_low,
    output logic [SAMPLE_W-1:0]  left_high,
    output logic [SAMPLE_W-1:0]  right_high
);

    // Coefficients
    logic [COEF_W-1:0] b0_k1_reg, b0_k2_reg, b1_k1_reg, b1_k2_reg;

    // Control
    state_t  state_reg, state_next;
    lat_op_t op_reg;
    logic    chan_reg;
    logic    phase_reg;
    logic    out_valid_reg;

    // Datapath
    logic [SAMPLE_W-1:0] x_reg [2];
    logic [SAMPLE_W-1:0] lat_mem_reg [8];
    logic [SAMPLE_W-1:0] held_reg [2];
    logic [SAMPLE_W-1:0] half0_reg [2];
    logic [SAMPLE_W-1:0] t_reg;
    logic [SAMPLE_W-1:0] m1_hold_reg;
    logic [SAMPLE_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0] left_low_reg, right_low_reg, left_high_reg, right_high_reg;

    logic [2:0]            mem_addr;
    logic [SAMPLE_W-1:0]   mem_rd;
    logic [COEF_W-1:0]     coef;
    logic [SAMPLE_W-1:0]   mult_data;
    logic signed [47:0]    mult_full;
    logic [SAMPLE_W-1:0]   sum_y;
    logic                  last_step;
    logic                  in_fire;
    logic                  out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign last_step = (state_reg == ST_ACC) && (op_reg == OP_INNER_OUT) && chan_reg;

    // Delay read: ops on the outer stage use m2, inner stage uses m1
    assign mem_addr = {chan_reg, phase_reg, ~op_reg[1]};
    assign mem_rd   = lat_mem_reg[mem_addr];

    // Shared multiplier operands
    always_comb
    begin
        unique case ({phase_reg, op_reg[1]})
            2'b00:   coef = b0_k2_reg;
            2'b01:   coef = b0_k1_reg;
            2'b10:   coef = b1_k2_reg;
            default: coef = b1_k1_reg;
        endcase
    end

    assign mult_data = op_reg[0] ? t_reg : mem_rd;
    assign mult_full = $signed({{(48-COEF_W){1'b0}}, coef})
                     * $signed({{(48-SAMPLE_W){mult_data[SAMPLE_W-1]}}, mult_data});
    assign sum_y     = prod_reg + mem_rd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_k1_reg <= '0;
            b0_k2_reg <= '0;
            b1_k1_reg <= '0;
            b1_k2_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_BRANCH0_K1: b0_k1_reg <= cfg_data;
                REG_BRANCH0_K2: b0_k2_reg <= cfg_data;
                REG_BRANCH1_K1: b1_k1_reg <= cfg_data;
                REG_BRANCH1_K2: b1_k2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (last_step)
                    state_next = phase_reg ? ST_IDLE : ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_OUTER_IN;
            chan_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                op_reg   <= OP_OUTER_IN;
                chan_reg <= 1'b0;
            end
            else if (state_reg == ST_ACC)
            begin
                op_reg <= lat_op_t'(op_reg + 2'd1);
                if (op_reg == OP_INNER_OUT)
                    chan_reg <= ~chan_reg;
            end
            // Phase flips when the item is done
            if (last_step && phase_reg)
                phase_reg <= 1'b0;
            else if (state_reg == ST_FIN && out_free)
                phase_reg <= 1'b1;
            // Output register
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Lattice delays and held halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                lat_mem_reg[i] <= '0;
            held_reg[0] <= '0;
            held_reg[1] <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            unique case (op_reg)
                OP_OUTER_OUT:
                begin
                    if (phase_reg)
                        held_reg[chan_reg] <= halve(sum_y);
                end
                OP_INNER_IN:
                    lat_mem_reg[{chan_reg, phase_reg, 1'b0}] <= t_reg - prod_reg;
                OP_INNER_OUT:
                    lat_mem_reg[{chan_reg, phase_reg, 1'b1}] <= m1_hold_reg + prod_reg;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg[0] <= left_sample;
            x_reg[1] <= right_sample;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mult_full[46:15];
            if (op_reg == OP_INNER_IN)
                m1_hold_reg <= mem_rd;
        end
        if (state_reg == ST_ACC)
        begin
            unique case (op_reg)
                OP_OUTER_IN:
                    t_reg <= x_reg[chan_reg] - prod_reg;
                OP_OUTER_OUT:
                begin
                    if (!phase_reg)
                        half0_reg[chan_reg] <= halve(sum_y);
                end
                OP_INNER_IN:
                    t_reg <= t_reg - prod_reg;
                default: ;
            endcase
        end
        if (state_reg == ST_FIN && out_free)
        begin
            left_low_reg   <= half0_reg[0] + held_reg[0];
            right_low_reg  <= half0_reg[1] + held_reg[1];
            left_high_reg  <= half0_reg[0] - held_reg[0];
            right_high_reg <= half0_reg[1] - held_reg[1];
        end
    end

    assign left_low   = left_low_reg;
    assign right_low  = right_low_reg;
    assign left_high  = left_high_reg;
    assign right_high = right_high_reg;

    // An accepted item always starts with the first product of the left channel
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_MUL) && (op_reg == OP_OUTER_IN) && !chan_reg)
        else $error("item did not start at first lattice step");

    // Only even-phase items reach the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> !phase_reg)
        else $error("odd-phase item reached output stage");

    // Odd-phase item ends by returning to idle with phase cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_step && phase_reg) |=> (state_reg == ST_IDLE) && !phase_reg)
        else $error("odd-phase item did not finish cleanly");

    // A new result appears only after the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside output stage");

endmodule

### tb/stereo_allpass_qmf_analysis_top_test.sv
`timescale 1ns / 100ps

module stereo_allpass_qmf_analysis_top_test;
    import saqmf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_CYCLES    = 1_000_000;
    localparam int SWEEP_PHASES  = 12;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;
    localparam logic [COEF_W-1:0]    COEF_MAX   = 15'h7FFF;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MIN = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_low;
        logic [SAMPLE_W-1:0] right_low;
        logic [SAMPLE_W-1:0] left_high;
        logic [SAMPLE_W-1:0] right_high;
    } bands_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [COEF_W-1:0]    cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [SAMPLE_W-1:0]  left_sample  = '0;
    logic [SAMPLE_W-1:0]  right_sample = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [SAMPLE_W-1:0]  left_low;
    logic [SAMPLE_W-1:0]  right_low;
    logic [SAMPLE_W-1:0]  left_high;
    logic [SAMPLE_W-1:0]  right_high;

    // Filter bank mirror: coefficients, lattice delays, held odd-branch halves, phase
    logic [COEF_W-1:0]   coef [4]      = '{default: '0};
    logic [SAMPLE_W-1:0] lat_mem [8]   = '{default: '0};
    logic [SAMPLE_W-1:0] held_half [2] = '{default: '0};
    bit                  odd_phase     = 1'b0;

    bands_t expected_bands [$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    int     hold_request   = 0;
    bit     tx_idle        = 1'b0;
    bit     rx_idle        = 1'b0;

    stereo_allpass_qmf_analysis_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_low     (left_low),
        .right_low    (right_low),
        .left_high    (left_high),
        .right_high   (right_high)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Q15 product, floored: (k * x) >> 15 on the signed sample
    function automatic logic [SAMPLE_W-1:0] q15_mul(logic [COEF_W-1:0] k,
                                                    logic [SAMPLE_W-1:0] x);
        longint      prod;
        logic [63:0] shifted;
        prod    = longint'({1'b0, k}) * longint'($signed(x));
        shifted = prod >>> 15;
        return shifted[SAMPLE_W-1:0];
    endfunction

    // Second-order lattice allpass on delays lat_mem[base] (inner), [base+1] (outer)
    function automatic logic [SAMPLE_W-1:0] allpass_step(logic [COEF_W-1:0] k1,
                                                         logic [COEF_W-1:0] k2,
                                                         int base,
                                                         logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] t;
        logic [SAMPLE_W-1:0] y;
        t = x - q15_mul(k2, lat_mem[base+1]);
        y = q15_mul(k2, t) + lat_mem[base+1];
        t = t - q15_mul(k1, lat_mem[base]);
        lat_mem[base+1] = lat_mem[base] + q15_mul(k1, t);
        lat_mem[base] = t;
        return y;
    endfunction

    // Advance the band split by one stereo pair; even phase queues a result
    task automatic advance_filter_bank(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        logic [SAMPLE_W-1:0] x [2];
        logic [SAMPLE_W-1:0] lo [2];
        logic [SAMPLE_W-1:0] hi [2];
        logic [SAMPLE_W-1:0] b0;
        x[0] = l;
        x[1] = r;
        if (odd_phase)
        begin
            for (int c = 0; c < 2; c++)
                held_half[c] = $signed(allpass_step(coef[REG_BRANCH1_K1],
                                                    coef[REG_BRANCH1_K2],
                                                    c * 4 + 2, x[c])) >>> 1;
            odd_phase = 1'b0;
        end
        else
        begin
            for (int c = 0; c < 2; c++)
            begin
                b0 = $signed(allpass_step(coef[REG_BRANCH0_K1], coef[REG_BRANCH0_K2],
                                          c * 4, x[c])) >>> 1;
                lo[c] = b0 + held_half[c];
                hi[c] = b0 - held_half[c];
            end
            expected_bands.push_back('{lo[0], lo[1], hi[0], hi[1]});
            odd_phase = 1'b1;
        end
    endtask

    // Mostly no gap, sometimes short, rarely long
    function automatic int pick_gap(bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0: return SAMPLE_MAX;
                1: return SAMPLE_MIN;
                2: return '0;
                3: return SAMPLE_NEG;
                default: return 32'd1;
            endcase
        end
        if (r < 4)
            return $urandom_range(0, 4000) - 2000;
        return $urandom;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_MAX;
            default: return COEF_W'($urandom_range(0, COEF_MAX));
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                 logic [SAMPLE_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        int gap;
        left_sample  <= l;
        right_sample <= r;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_filter_bank(l, r);
        gap = pick_gap(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering, wait for every queued result, then let an odd item finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        if (idx < REG_UNUSED_FIRST)
            coef[idx] = data;
    endtask

    task automatic set_coefs(logic [COEF_W-1:0] b0k1, logic [COEF_W-1:0] b0k2,
                             logic [COEF_W-1:0] b1k1, logic [COEF_W-1:0] b1k2);
        wait_drained();
        write_reg(REG_BRANCH0_K1, b0k1);
        write_reg(REG_BRANCH0_K2, b0k2);
        write_reg(REG_BRANCH1_K1, b1k1);
        write_reg(REG_BRANCH1_K2, b1k2);
        cfg_write_en <= 1'b0;
    endtask

    // Reset coefficients are zero; the first even item sees a zero held half
    task automatic test_reset_values();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair('0, SAMPLE_NEG);
        send_pair(SAMPLE_NEG, '0);
        send_pair(32'd1, 32'hFFFF_FFFE);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
    endtask

    // Extreme coefficients with extreme samples force wrapping in the lattice
    task automatic test_extremes();
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_NEG, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_NEG);
        set_coefs(COEF_MAX, '0, 15'd1, 15'h4000);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, '0);
        send_pair('0, SAMPLE_MIN);
        send_pair(SAMPLE_NEG, SAMPLE_NEG);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
    endtask

    // Writes to indexes past the last register change nothing
    task automatic test_unused_registers();
        wait_drained();
        write_reg(REG_UNUSED_FIRST, COEF_MAX);
        for (int i = 1; i < 4; i++)
            write_reg(REG_UNUSED_FIRST + CFG_IDX_W'(i), rand_coef());
        cfg_write_en <= 1'b0;
        for (int i = 0; i < 4; i++)
            send_pair(rand_sample(), rand_sample());
    endtask

    // Long receiver hold while the sender keeps offering: the block fills up
    task automatic test_backpressure();
        set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_request = 400;
        for (int i = 0; i < 14; i++)
            send_pair(rand_sample(), rand_sample());
    endtask

    // Sender pauses mid-stream until everything expected has come out
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int round = 0; round < 3; round++)
        begin
            for (int i = 0; i < 7; i++)
                send_pair(rand_sample(), rand_sample());
            wait_drained();
        end
    endtask

    // Random content across coefficient settings; lattice memory carries over
    task automatic test_random_sweep();
        int count;
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            case (ph)
                0: set_coefs('0, '0, '0, '0);
                1: set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
                2: set_coefs('0, COEF_MAX, COEF_MAX, '0);
                default: set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
            endcase
            tx_idle = (ph % 4 != 3);
            rx_idle = (ph % 4 != 3);
            count = $urandom_range(110, 156);
            for (int i = 0; i < count; i++)
                send_pair(rand_sample(), rand_sample());
        end
    endtask

    // Result sink: random stalls, plus long holds on request
    initial
    begin : result_sink
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall == 0)
                stall = pick_gap(rx_idle);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        bands_t want;
        if (out_valid && out_ready)
        begin
            if (expected_bands.size() == 0)
                flag_mismatch("unexpected result, left_low", left_low, 'x);
            else
            begin
                want = expected_bands.pop_front();
                if (left_low !== want.left_low)
                    flag_mismatch("left_low", left_low, want.left_low);
                if (right_low !== want.right_low)
                    flag_mismatch("right_low", right_low, want.right_low);
                if (left_high !== want.left_high)
                    flag_mismatch("left_high", left_high, want.left_high);
                if (right_high !== want.right_high)
                    flag_mismatch("right_high", right_high, want.right_high);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : test_sequence
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_extremes();
        test_unused_registers();
        test_backpressure();
        test_drain_pause();
        test_random_sweep();
        wait_drained();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
